// ===== rtl/gb_pkg.sv =====
package gb_pkg;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_DATA_W     = 13;
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int ROW_W          = 12;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int MIN_DIM        = 3;

  // Channel sums: 16 * 255 fits in 12 bits
  localparam int SUM_W        = 12;
  localparam int KERNEL_SHIFT = 4;

  // Kernel weights, [row][col], row 0 oldest
  localparam logic [2:0] KERN [0:2][0:2] = '{
    '{3'd1, 3'd2, 3'd1},
    '{3'd2, 3'd4, 3'd2},
    '{3'd1, 3'd2, 3'd1}
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } result_t;

  // 3x3 neighborhood, [row][col], col 2 newest
  typedef pixel_t [2:0][2:0] window_t;

endpackage

// ===== rtl/gb_line_buf.sv =====
module gb_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              mid_we,
  input  gb_pkg::pixel_t    mid_wdata,
  input  logic              up_we,
  input  logic [AW-1:0]     up_waddr,
  input  gb_pkg::pixel_t    up_wdata,
  output gb_pkg::pixel_t    up_rd,
  output gb_pkg::pixel_t    mid_rd
);
  import gb_pkg::*;

  pixel_t upper  [DEPTH];
  pixel_t middle [DEPTH];

  // Middle row: read-before-write at the column of the incoming pixel
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_rd <= middle[rd_addr];
    end
    if (mid_we) begin
      middle[rd_addr] <= mid_wdata;
    end
  end

  // Upper row: takes the old middle word from the registered middle read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_rd <= upper[rd_addr];
    end
    if (up_we) begin
      upper[up_waddr] <= up_wdata;
    end
  end

endmodule

// ===== rtl/gb_filter.sv =====
module gb_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              win_valid,
  input  logic              win_last,
  input  gb_pkg::window_t   win,
  output logic              out_valid,
  output gb_pkg::result_t   out_data
);
  import gb_pkg::*;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  result_t          res_next;

  // Weighted 9-term sum per channel, then truncate by the kernel scale
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum_r = sum_r + SUM_W'(win[r][c].red)   * SUM_W'(KERN[r][c]);
        sum_g = sum_g + SUM_W'(win[r][c].green) * SUM_W'(KERN[r][c]);
        sum_b = sum_b + SUM_W'(win[r][c].blue)  * SUM_W'(KERN[r][c]);
      end
    end
    res_next.red_out    = sum_r[KERNEL_SHIFT +: 8];
    res_next.green_out  = sum_g[KERNEL_SHIFT +: 8];
    res_next.blue_out   = sum_b[KERNEL_SHIFT +: 8];
    res_next.frame_last = win_last;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && win_valid) begin
      out_data <= res_next;
    end
  end

endmodule

// ===== rtl/gaussian_blur_3x3_rgb.sv =====
// Streaming 3x3 Gaussian blur of RGB pixels in raster order. One pixel word is
// taken per clock and at most one result word leaves per clock; results come
// only for interior centers, one row and one column behind the input. The
// result word for an accepted pixel passes through the line buffer read with
// the input register, then the window, then the output register; while the
// output word is stalled the whole pipe holds and in_ready drops. frame_last
// marks the final interior pixel of the frame. frame_width and frame_height
// are clamped to 3..MAX_LINE_WIDTH and 3..4096; the user must write them only
// while no word is in flight, which the block does not enforce. A write
// mid-frame keeps the counters, which wrap once they reach the new limit. Line
// buffers are block RAMs with one read and one write per cycle each and need
// no clearing after reset.
module gaussian_blur_3x3_rgb #(
  parameter int MAX_LINE_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gb_pkg::pixel_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gb_pkg::result_t                 out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [gb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gb_pkg::*;

  localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int DW = 14;
  localparam logic [DW-1:0] MAXW = DW'(MAX_LINE_WIDTH);

  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [CW-1:0]             col_count;
  logic [ROW_W-1:0]          row_count;

  logic [DW-1:0]             w_eff;
  logic [FRAME_HEIGHT_W-1:0] h_eff;
  logic [DW-1:0]             col_inc;
  logic [FRAME_HEIGHT_W-1:0] row_inc;
  logic                      en;
  logic                      accept;
  logic                      produce;
  logic                      at_last;

  logic                      s1_valid;
  logic                      s1_produce;
  logic                      s1_last;
  logic [CW-1:0]             s1_col;
  pixel_t                    s1_pix;
  pixel_t                    up_rd;
  pixel_t                    mid_rd;

  window_t                   win;
  logic                      win_valid;
  logic                      win_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_W'(640);
      frame_height <= FRAME_HEIGHT_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame size
  always_comb begin
    if (DW'(frame_width) < DW'(MIN_DIM)) begin
      w_eff = DW'(MIN_DIM);
    end else if (DW'(frame_width) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = DW'(frame_width);
    end
    if (frame_height < FRAME_HEIGHT_W'(MIN_DIM)) begin
      h_eff = FRAME_HEIGHT_W'(MIN_DIM);
    end else if (frame_height > FRAME_HEIGHT_W'(HEIGHT_LIMIT)) begin
      h_eff = FRAME_HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Whole pipe advances unless the output word is stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  assign col_inc = DW'(col_count) + DW'(1);
  assign row_inc = FRAME_HEIGHT_W'(row_count) + FRAME_HEIGHT_W'(1);
  assign produce = (row_count >= ROW_W'(2)) && (DW'(col_count) >= DW'(2));
  assign at_last = (FRAME_HEIGHT_W'(row_count) == h_eff - FRAME_HEIGHT_W'(1))
                && (DW'(col_count) == w_eff - DW'(1));

  // Raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_count <= '0;
        if (row_inc >= h_eff) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[ROW_W-1:0];
        end
      end else begin
        col_count <= col_inc[CW-1:0];
      end
    end
  end

  // Stage 1: pixel alongside the line buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_produce <= produce;
      s1_last    <= at_last;
      s1_col     <= col_count;
      s1_pix     <= in_data;
    end
  end

  gb_line_buf #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (en),
    .rd_addr   (col_count),
    .mid_we    (accept),
    .mid_wdata (in_data),
    .up_we     (en && s1_valid),
    .up_waddr  (s1_col),
    .up_wdata  (mid_rd),
    .up_rd     (up_rd),
    .mid_rd    (mid_rd)
  );

  // Stage 2: 3x3 window shifts once per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (en) begin
      win_valid <= s1_valid && s1_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_rd;
      win[1][2] <= mid_rd;
      win[2][2] <= s1_pix;
      win_last  <= s1_last;
    end
  end

  gb_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .win_valid (win_valid),
    .win_last  (win_last),
    .win       (win),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    DW'(col_count) < MAXW)
    else $error("column counter beyond line buffer depth");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && at_last |=> (col_count == '0) && (row_count == '0))
    else $error("counters did not wrap at frame end");

  a_result_from_window: assert property (@(posedge clk) disable iff (rst)
    en && win_valid |=> out_valid)
    else $error("window result lost on its way out");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gb_pkg::*;

  localparam int LINE_DEPTH     = 2048;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 18;

  // Directed row: {pixel, typed, expected word}; typed = 0 means predictor only
  localparam logic [25:0] UNCHECKED = '0;
  localparam logic [49:0] DIRECTED [DIRECTED_ROWS] = '{
    // 3x3 frame, all channels at full scale
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, UNCHECKED},
    {24'hFFFFFF, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
    // 3x3 frame, lone center pixel: only the weight-4 tap contributes
    {24'h000000, UNCHECKED},
    {24'h000000, UNCHECKED},
    {24'h000000, UNCHECKED},
    {24'h000000, UNCHECKED},
    {8'd255, 8'd128, 8'd1, UNCHECKED},
    {24'h000000, UNCHECKED},
    {24'h000000, UNCHECKED},
    {24'h000000, UNCHECKED},
    {24'h000000, 1'b1, 8'd63, 8'd32, 8'd0, 1'b1}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pixel_t                in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_data;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  gaussian_blur_3x3_rgb #(
    .MAX_LINE_WIDTH(LINE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Blur predictor state
  pixel_t                    line_above [LINE_DEPTH];
  pixel_t                    line_prev  [LINE_DEPTH];
  pixel_t                    nbhd [3][3];
  int unsigned               next_col;
  int unsigned               next_row;
  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;

  result_t     blurred_q [$];
  result_t     blurred_want;
  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles;
  bit          pressure_go;
  bit          hold_done;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_above[i] = '0;
      line_prev[i]  = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nbhd[r][c] = '0;
      end
    end
    next_col       = 0;
    next_row       = 0;
    width_reg      = 12'd640;
    height_reg     = 13'd480;
    mismatch_count = 0;
    pixels_sent    = 0;
    burst_left     = 0;
    pressure_go    = 1'b0;
    hold_done      = 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One raster pixel through line stores, window and kernel
  task automatic blur_predict(input pixel_t p, output bit produced, output result_t res);
    int unsigned w, h, wt, sr, sg, sb;
    pixel_t      up, mid;
    w   = clamp_dim(width_reg, MIN_DIM, LINE_DEPTH);
    h   = clamp_dim(height_reg, MIN_DIM, HEIGHT_LIMIT);
    up  = line_above[next_col];
    mid = line_prev[next_col];
    line_above[next_col] = mid;
    line_prev[next_col]  = p;
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = mid;
    nbhd[2][2] = p;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wt = (r == 1 ? 2 : 1) * (c == 1 ? 2 : 1);
        sr += nbhd[r][c].red * wt;
        sg += nbhd[r][c].green * wt;
        sb += nbhd[r][c].blue * wt;
      end
    end
    produced       = (next_row >= 2) && (next_col >= 2);
    res.red_out    = 8'(sr >> KERNEL_SHIFT);
    res.green_out  = 8'(sg >> KERNEL_SHIFT);
    res.blue_out   = 8'(sb >> KERNEL_SHIFT);
    res.frame_last = (next_row == h - 1) && (next_col == w - 1);
    // counters wrap once they reach or pass the limit
    if (next_col + 1 >= w) begin
      next_col = 0;
      next_row = (next_row + 1 >= h) ? 0 : ((next_row + 1) & 12'hFFF);
    end else begin
      next_col = (next_col + 1) & 11'h7FF;
    end
  endtask

  // Sender gap: mostly short, a few long, occasional bursts with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Channel level biased toward the rails
  function automatic logic [7:0] rand_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = rand_level();
    p.green = rand_level();
    p.blue  = rand_level();
    return p;
  endfunction

  // Offer one pixel word, predict on acceptance
  task automatic send_pixel(input pixel_t p, input bit typed, input result_t want);
    int unsigned gap;
    bit          produced;
    result_t     res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_ready !== 1'b1);
    pixels_sent++;
    blur_predict(p, produced, res);
    if (produced || typed) blurred_q.push_back(typed ? want : res);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(random_pixel(), 1'b0, '0);
  endtask

  // Send until the raster position wraps back to the frame origin
  task automatic finish_frames(input int unsigned frames);
    repeat (frames) begin
      do send_pixel(random_pixel(), 1'b0, '0);
      while (next_col != 0 || next_row != 0);
    end
  endtask

  // Register write with the block drained and settled
  task automatic write_cfg(input logic idx, input int unsigned value);
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = FRAME_WIDTH_W'(value);
    else height_reg = FRAME_HEIGHT_W'(value);
  endtask

  task automatic write_frame_size(input int unsigned wv, input int unsigned hv);
    if ($urandom_range(0, 1) == 0) begin
      write_cfg(REG_FRAME_WIDTH, wv);
      write_cfg(REG_FRAME_HEIGHT, hv);
    end else begin
      write_cfg(REG_FRAME_HEIGHT, hv);
      write_cfg(REG_FRAME_WIDTH, wv);
    end
  endtask

  // Stimulus
  initial begin
    int unsigned base, wv, hv, r, area;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_frame_size(3, 3);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_pixel(DIRECTED[i][49:26], DIRECTED[i][25], DIRECTED[i][24:0]);
    end

    // shrink width, then height, partway through a frame
    write_frame_size(8, 7);
    send_random(29);
    write_cfg(REG_FRAME_WIDTH, 4);
    send_random(5);
    write_cfg(REG_FRAME_HEIGHT, 4);
    finish_frames(2);

    // small random frames, some sizes below the minimum
    base = pixels_sent;
    while (pixels_sent - base < RANDOM_ITEMS) begin
      r  = $urandom_range(0, 99);
      wv = (r < 10) ? $urandom_range(0, 2) : (r < 80) ? $urandom_range(3, 16) :
           $urandom_range(17, 64);
      r  = $urandom_range(0, 99);
      hv = (r < 10) ? $urandom_range(0, 2) : (r < 85) ? $urandom_range(3, 8) :
           $urandom_range(9, 20);
      write_frame_size(wv, hv);
      area = clamp_dim(wv, MIN_DIM, LINE_DEPTH) * clamp_dim(hv, MIN_DIM, HEIGHT_LIMIT);
      finish_frames(area > 300 ? 1 : $urandom_range(1, 3));
    end

    // widest line, width saturates from above; first row cut short
    write_frame_size(4095, 3);
    send_random(41);
    write_cfg(REG_FRAME_WIDTH, 4);
    finish_frames(1);

    // tallest frame, both saturate; long output hold partway in
    write_frame_size(2, 8191);
    send_random(30);
    pressure_go = 1'b1;
    send_random(60);
    write_cfg(REG_FRAME_HEIGHT, 5);
    finish_frames(1);

    write_frame_size(5, 4);
    finish_frames(2);

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && blurred_q.size() == 0) begin
      $display("gaussian_blur_3x3_rgb test passed");
    end else begin
      $display("gaussian_blur_3x3_rgb test failed");
    end
    $finish;
  end

  // Receiver: random ready pattern plus one long hold-off
  initial begin
    int unsigned high_len, low_len, r;
    while (rst) @(posedge clk);
    forever begin
      if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r        = $urandom_range(0, 99);
      high_len = (r < 5) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      r        = $urandom_range(0, 99);
      low_len  = (r < 45) ? 0 : (r < 85) ? $urandom_range(1, 3) :
                 (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 40);
      out_ready <= 1'b1;
      repeat (high_len) begin
        @(posedge clk);
        if (pressure_go && !hold_done) break;
      end
      if (low_len != 0) begin
        out_ready <= 1'b0;
        repeat (low_len) begin
          @(posedge clk);
          if (pressure_go && !hold_done) break;
        end
      end
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (blurred_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected result word: r=%0d g=%0d b=%0d last=%0b",
                   out_data.red_out, out_data.green_out, out_data.blue_out,
                   out_data.frame_last);
        end
        mismatch_count++;
      end else begin
        blurred_want = blurred_q.pop_front();
        if (out_data.red_out !== blurred_want.red_out ||
            out_data.green_out !== blurred_want.green_out ||
            out_data.blue_out !== blurred_want.blue_out ||
            out_data.frame_last !== blurred_want.frame_last) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                     blurred_want.red_out, blurred_want.green_out, blurred_want.blue_out,
                     blurred_want.frame_last, out_data.red_out, out_data.green_out,
                     out_data.blue_out, out_data.frame_last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("gaussian_blur_3x3_rgb test failed");
    $finish;
  end

endmodule
